/* rtl/tmf_pkg.sv */
`default_nettype none
package tmf_pkg;

	typedef enum logic [1:0] {
		OP_EDGE   = 2'd0,
		OP_RECENT = 2'd1,
		OP_MEDIAN = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_NOISE = 2'd0,
		REG_EPP   = 2'd1,
		REG_TPS   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MED_BIT,
		ST_MED_READ,
		ST_MED_CNT,
		ST_MED_NEXT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	localparam int PERIOD_W = 16;
	localparam int FREQ_W   = 20;
	localparam int EPP_W    = 4;

	localparam logic [PERIOD_W-1:0] NOISE_RST = 16'd200;
	localparam logic [EPP_W-1:0]    EPP_RST   = 4'd6;
	localparam logic [FREQ_W-1:0]   TPS_RST   = 20'd250000;

	typedef struct packed {
		logic                start;
		logic [FREQ_W-1:0]   dividend;
		logic [PERIOD_W:0]   divisor;
	} div_req_t;

endpackage
`default_nettype wire

/* rtl/tachometer_median_filter_unit.sv */
// channel | direction | signals
// in      | input     | in_valid, in_ready, op, timer_value
// out     | output    | out_valid, out_ready, from_median, frequency
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
// An edge or clear is handled in the idle state; a recent read goes through a start state,
// the 20-step divider and an output state before its beat is put out (a zero period skips the divider).
// A median read (when a recent period is held) ranks the ring one bit per pass: 16 passes per
// middle value, two middle values for an even depth, then the divide.
// After reset a clearing pass zeroes every entry of the sample memory.
// A waiting result holds the unit in its output state; edges, clears and reads all wait.
`default_nettype none
module tachometer_median_filter_unit #(
	parameter int SAMPLE_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] timer_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             from_median,
	output logic [19:0]      frequency,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int CW = $clog2(SAMPLE_DEPTH + 1);
	localparam int PW = tmf_pkg::PERIOD_W;
	localparam int RANK_LO = (SAMPLE_DEPTH - 1) / 2;
	localparam int RANK_HI = SAMPLE_DEPTH / 2;
	localparam bit EVEN = (SAMPLE_DEPTH % 2) == 0;

	logic [PW-1:0] mem [SAMPLE_DEPTH];
	logic [PW-1:0] rd_data_q;

	tmf_pkg::state_t state_q, state_d;

	logic [PW-1:0]  noise_q;
	logic [3:0]     epp_q;
	logic [19:0]    tps_q;
	logic [3:0]     edge_cnt_q;
	logic [PW-1:0]  start_q;
	logic [PW-1:0]  recent_q;
	logic [AW-1:0]  widx_q;
	logic [AW-1:0]  addr_q;
	logic [CW-1:0]  k_q;
	logic [CW-1:0]  zeros_q;
	logic [PW-1:0]  prefix_q;
	logic [3:0]     bit_q;
	logic           second_q;
	logic [PW-1:0]  lo_val_q;
	logic [PW:0]    period_q;
	logic           med_q;
	logic           med_out_q;
	logic           out_valid_q;
	logic [19:0]    freq_q;

	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [PW-1:0]  mem_wd;
	logic [AW-1:0]  mem_ra;
	logic           match;
	tmf_pkg::div_req_t div_req;
	logic           div_busy;
	logic [19:0]    div_quo;
	logic [4:0]     cnt_inc;
	logic [3:0]     epp_eff;
	logic [PW-1:0]  period_new;
	logic [PW-1:0]  cand;
	logic           out_load;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	assign mem_ra = addr_q;

	tmf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign in_ready  = (state_q == tmf_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign from_median = med_out_q;
	assign frequency   = freq_q;
	assign out_load    = (state_q == tmf_pkg::ST_OUT) && (!out_valid_q || out_ready);

	assign epp_eff    = (epp_q == '0) ? 4'd1 : epp_q;
	assign cnt_inc    = {1'b0, edge_cnt_q} + 5'd1;
	assign period_new = timer_value - start_q;

	// candidate prefix with current bit cleared: count entries whose top bits match
	always_comb begin
		logic [PW-1:0] mask;
		mask  = ~((PW'(1) << bit_q) - PW'(1));
		cand  = prefix_q;
		match = ((rd_data_q ^ prefix_q) & mask) == '0;
	end

	always_comb begin
		state_d        = state_q;
		mem_we         = 1'b0;
		mem_wa         = widx_q;
		mem_wd         = period_new;
		div_req.start    = 1'b0;
		div_req.dividend = tps_q;
		div_req.divisor  = period_q;
		case (state_q)
			tmf_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = addr_q;
				mem_wd = '0;
				if (addr_q == AW'(SAMPLE_DEPTH - 1)) begin
					state_d = tmf_pkg::ST_IDLE;
				end
			end
			tmf_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (tmf_pkg::op_t'(op))
						tmf_pkg::OP_EDGE: begin
							if (edge_cnt_q != '0 && cnt_inc >= {1'b0, epp_eff} + 5'd1
									&& period_new > noise_q) begin
								mem_we = 1'b1;
							end
						end
						tmf_pkg::OP_RECENT: state_d = tmf_pkg::ST_DIV_START;
						tmf_pkg::OP_MEDIAN: state_d = (recent_q == '0) ?
							tmf_pkg::ST_DIV_START : tmf_pkg::ST_MED_BIT;
						default: ;
					endcase
				end
			end
			tmf_pkg::ST_MED_BIT:  state_d = tmf_pkg::ST_MED_READ;
			tmf_pkg::ST_MED_READ: state_d = tmf_pkg::ST_MED_CNT;
			tmf_pkg::ST_MED_CNT: begin
				if (addr_q == '0) begin
					state_d = tmf_pkg::ST_MED_NEXT;
				end
			end
			tmf_pkg::ST_MED_NEXT: begin
				if (bit_q != '0) begin
					state_d = tmf_pkg::ST_MED_BIT;
				end else if (EVEN && !second_q) begin
					state_d = tmf_pkg::ST_MED_BIT;
				end else begin
					state_d = tmf_pkg::ST_DIV_START;
				end
			end
			tmf_pkg::ST_DIV_START: begin
				div_req.start = (period_q != '0);
				state_d = (period_q != '0) ? tmf_pkg::ST_DIV_WAIT : tmf_pkg::ST_OUT;
			end
			tmf_pkg::ST_DIV_WAIT: begin
				if (!div_busy) begin
					state_d = tmf_pkg::ST_OUT;
				end
			end
			tmf_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = tmf_pkg::ST_IDLE;
				end
			end
			default: state_d = tmf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmf_pkg::ST_CLEAR;
			noise_q     <= tmf_pkg::NOISE_RST;
			epp_q       <= tmf_pkg::EPP_RST;
			tps_q       <= tmf_pkg::TPS_RST;
			edge_cnt_q  <= '0;
			start_q     <= '0;
			recent_q    <= '0;
			widx_q      <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (tmf_pkg::reg_idx_t'(cfg_index))
					tmf_pkg::REG_NOISE: noise_q <= cfg_data[PW-1:0];
					tmf_pkg::REG_EPP:   epp_q   <= cfg_data[3:0];
					tmf_pkg::REG_TPS:   tps_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tmf_pkg::ST_CLEAR: begin
					addr_q <= (addr_q == AW'(SAMPLE_DEPTH - 1)) ? '0 : addr_q + 1'b1;
				end
				tmf_pkg::ST_IDLE: begin
					if (in_valid && in_ready) begin
						case (tmf_pkg::op_t'(op))
							tmf_pkg::OP_EDGE: begin
								if (edge_cnt_q == '0) begin
									start_q    <= timer_value;
									edge_cnt_q <= 4'd1;
								end else if (cnt_inc >= {1'b0, epp_eff} + 5'd1) begin
									if (period_new > noise_q) begin
										recent_q <= period_new;
										widx_q <= (widx_q == AW'(SAMPLE_DEPTH - 1)) ?
											'0 : widx_q + 1'b1;
									end
									edge_cnt_q <= '0;
								end else begin
									edge_cnt_q <= cnt_inc[3:0];
								end
							end
							tmf_pkg::OP_CLEAR: recent_q <= '0;
							default: ;
						endcase
					end
				end
				tmf_pkg::ST_MED_BIT,
				tmf_pkg::ST_MED_READ: addr_q <= addr_q + 1'b1;
				tmf_pkg::ST_MED_CNT: begin
					addr_q <= (addr_q == AW'(SAMPLE_DEPTH - 1) || addr_q == '0) ?
						'0 : addr_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// rank search: at each bit, count matching entries with that bit clear
	always_ff @(posedge clk) begin
		case (state_q)
			tmf_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					med_q    <= (op == tmf_pkg::OP_MEDIAN);
					period_q <= {1'b0, recent_q};
					prefix_q <= '0;
					bit_q    <= 4'(PW - 1);
					k_q      <= CW'(RANK_LO);
					second_q <= 1'b0;
					zeros_q  <= '0;
				end
			end
			tmf_pkg::ST_MED_BIT: zeros_q <= '0;
			tmf_pkg::ST_MED_READ,
			tmf_pkg::ST_MED_CNT: begin
				if (match && !rd_data_q[bit_q]) begin
					zeros_q <= zeros_q + 1'b1;
				end
			end
			tmf_pkg::ST_MED_NEXT: begin
				if (bit_q == '0 && EVEN && !second_q) begin
					second_q <= 1'b1;
					lo_val_q <= (k_q >= zeros_q) ? (cand | PW'(1)) : cand;
					prefix_q <= '0;
					bit_q    <= 4'(PW - 1);
					k_q      <= CW'(RANK_HI);
				end else begin
					if (k_q >= zeros_q) begin
						prefix_q[bit_q] <= 1'b1;
						k_q <= k_q - zeros_q;
					end
					if (bit_q != '0) begin
						bit_q <= bit_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			med_out_q <= med_q;
			freq_q    <= (period_q == '0) ? '0 : div_quo;
		end
		if (state_q == tmf_pkg::ST_MED_NEXT && bit_q == '0 && (!EVEN || second_q)) begin
			if (EVEN) begin
				period_q <= ({1'b0, lo_val_q} +
					{1'b0, (k_q >= zeros_q) ? (cand | PW'(1)) : cand}) >> 1;
			end else begin
				period_q <= {1'b0, (k_q >= zeros_q) ? (cand | PW'(1)) : cand};
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/tmf_divider.sv */
`default_nettype none
module tmf_divider (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tmf_pkg::div_req_t                  req,
	output logic                                    busy,
	output logic [tmf_pkg::FREQ_W-1:0]              quotient
);

	localparam int DW = tmf_pkg::FREQ_W;
	localparam int VW = tmf_pkg::PERIOD_W + 1;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW:0]   rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic [VW:0]   trial;

	assign trial = {rem_q[VW-1:0], quo_q[DW-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			if (!trial[VW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[VW-1:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule
`default_nettype wire
